@@ rtl/core/abe_pkg.sv @@
// ----------------------------------------------------------------------------
// Alignment block extractor package
// Shared constants, controller state type and command/status structs.
// ----------------------------------------------------------------------------
package abe_pkg;

   localparam int MAX_SEQUENCES = 32;
   localparam int MAX_COLUMNS   = 65536;
   localparam int LANE_W        = $clog2(MAX_SEQUENCES);

   localparam int TAGS_W   = 64;
   localparam int NSEQ_W   = 6;
   localparam int CTR_W    = 17;
   localparam int START_W  = 16;
   localparam int BLKIDX_W = 17;
   localparam int LEN_W    = 17;
   localparam int CNT_W    = 6;

   localparam logic [1:0] TAG_UNALIGNED = 2'd1;
   localparam logic [1:0] TAG_ALIGNED   = 2'd2;

   localparam logic [NSEQ_W-1:0]   NSEQ_RESET = NSEQ_W'(2);
   localparam logic [BLKIDX_W-1:0] BLK_SAT    = '1;
   localparam logic [LEN_W-1:0]    RUN_MAX    = LEN_W'(MAX_COLUMNS);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DRAIN
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic has_records;
      logic last_record;
   } status_type;

endpackage

@@ rtl/core/abe_ctrl.sv @@
// ----------------------------------------------------------------------------
// Alignment block extractor controller
// Accepts columns while idle; drains records one per cycle unless stalled.
// ----------------------------------------------------------------------------
module abe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  abe_pkg::status_type status,
   output abe_pkg::cmd_type    cmd
);
   import abe_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      out_free   = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && status.has_records) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.pop = out_free;
            if (out_free && status.last_record) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/abe_datapath.sv @@
// ----------------------------------------------------------------------------
// Alignment block extractor datapath
// Residue counters, open block state, pending record masks and output stage.
// ----------------------------------------------------------------------------
module abe_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [abe_pkg::NSEQ_W-1:0]     csr_wr_data,
   input  logic [abe_pkg::TAGS_W-1:0]     req_column_tags,
   input  logic                           req_last_column,
   input  abe_pkg::cmd_type               cmd,
   output abe_pkg::status_type            status,
   output logic [abe_pkg::BLKIDX_W-1:0]   rsp_block_index,
   output logic [abe_pkg::LANE_W-1:0]     rsp_sequence_index,
   output logic [abe_pkg::START_W-1:0]    rsp_start_position,
   output logic [abe_pkg::LEN_W-1:0]      rsp_block_length,
   output logic [abe_pkg::CNT_W-1:0]      rsp_member_count,
   output logic                           rsp_all_aligned,
   output logic                           rsp_last_of_run
);
   import abe_pkg::*;

   function automatic logic [LANE_W-1:0] lowest_lane(input logic [MAX_SEQUENCES-1:0] m);
      logic [LANE_W-1:0] idx;
      idx = '0;
      for (int j = MAX_SEQUENCES - 1; j >= 0; j--) begin
         if (m[j]) idx = LANE_W'(j);
      end
      return idx;
   endfunction

   logic [NSEQ_W-1:0]        nseq_ff, nseq_in;
   logic [CTR_W-1:0]         ctr_ff [MAX_SEQUENCES];
   logic [CTR_W-1:0]         ctr_in [MAX_SEQUENCES];
   logic [START_W-1:0]       starts_ff [MAX_SEQUENCES];
   logic [START_W-1:0]       starts_in [MAX_SEQUENCES];
   logic [START_W-1:0]       snap_ff [MAX_SEQUENCES];
   logic [START_W-1:0]       snap_in [MAX_SEQUENCES];
   logic [MAX_SEQUENCES-1:0] pat_ff, pat_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     full_ff, full_in;
   logic                     no_open_ff, no_open_in;
   logic [LEN_W-1:0]         run_ff, run_in;
   logic [BLKIDX_W-1:0]      blocks_ff, blocks_in;

   logic [MAX_SEQUENCES-1:0] mask_a_ff, mask_a_in, mask_b_ff, mask_b_in;
   logic [BLKIDX_W-1:0]      a_idx_ff, a_idx_in, b_idx_ff, b_idx_in;
   logic [LEN_W-1:0]         a_len_ff, a_len_in, b_len_ff, b_len_in;
   logic [CNT_W-1:0]         a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   logic                     a_full_ff, a_full_in, b_full_ff, b_full_in;

   logic [BLKIDX_W-1:0]      o_idx_ff, o_idx_in;
   logic [LANE_W-1:0]        o_seq_ff, o_seq_in;
   logic [START_W-1:0]       o_start_ff, o_start_in;
   logic [LEN_W-1:0]         o_len_ff, o_len_in;
   logic [CNT_W-1:0]         o_cnt_ff, o_cnt_in;
   logic                     o_full_ff, o_full_in;
   logic                     o_last_ff, o_last_in;

   logic [NSEQ_W-1:0]        lanes;
   logic [1:0]               tag;
   logic [MAX_SEQUENCES-1:0] col_pat, col_adv;
   logic [CNT_W-1:0]         col_cnt;
   logic                     match, close_a, open_new;
   logic [MAX_SEQUENCES-1:0] nb_pat;
   logic [CNT_W-1:0]         nb_cnt;
   logic                     nb_full, nb_no_open;
   logic [LEN_W-1:0]         nb_run;
   logic [BLKIDX_W-1:0]      nb_blocks;
   logic [MAX_SEQUENCES-1:0] new_mask_a, new_mask_b;
   logic                     phase_a;
   logic [MAX_SEQUENCES-1:0] sel_mask, sel_bit;
   logic [LANE_W-1:0]        sel_lane;
   logic                     any_records, final_record;

   always_ff @(posedge clock) begin
      if (reset) begin
         nseq_ff    <= NSEQ_RESET;
         for (int j = 0; j < MAX_SEQUENCES; j++) ctr_ff[j] <= '1;
         pat_ff     <= '0;
         cnt_ff     <= '0;
         full_ff    <= 1'b0;
         no_open_ff <= 1'b1;
         run_ff     <= '0;
         blocks_ff  <= '0;
         mask_a_ff  <= '0;
         mask_b_ff  <= '0;
      end else begin
         nseq_ff    <= nseq_in;
         for (int j = 0; j < MAX_SEQUENCES; j++) ctr_ff[j] <= ctr_in[j];
         pat_ff     <= pat_in;
         cnt_ff     <= cnt_in;
         full_ff    <= full_in;
         no_open_ff <= no_open_in;
         run_ff     <= run_in;
         blocks_ff  <= blocks_in;
         mask_a_ff  <= mask_a_in;
         mask_b_ff  <= mask_b_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_SEQUENCES; j++) begin
         starts_ff[j] <= starts_in[j];
         snap_ff[j]   <= snap_in[j];
      end
      a_idx_ff   <= a_idx_in;
      a_len_ff   <= a_len_in;
      a_cnt_ff   <= a_cnt_in;
      a_full_ff  <= a_full_in;
      b_idx_ff   <= b_idx_in;
      b_len_ff   <= b_len_in;
      b_cnt_ff   <= b_cnt_in;
      b_full_ff  <= b_full_in;
      o_idx_ff   <= o_idx_in;
      o_seq_ff   <= o_seq_in;
      o_start_ff <= o_start_in;
      o_len_ff   <= o_len_in;
      o_cnt_ff   <= o_cnt_in;
      o_full_ff  <= o_full_in;
      o_last_ff  <= o_last_in;
   end

   // column decode and next block state
   always_comb begin
      lanes = (nseq_ff > NSEQ_W'(MAX_SEQUENCES)) ? NSEQ_W'(MAX_SEQUENCES) : nseq_ff;
      tag   = '0;
      for (int j = 0; j < MAX_SEQUENCES; j++) begin
         tag        = req_column_tags[2*j +: 2];
         col_pat[j] = (NSEQ_W'(j) < lanes) && (tag == TAG_ALIGNED);
         col_adv[j] = (NSEQ_W'(j) < lanes) && (tag == TAG_ALIGNED || tag == TAG_UNALIGNED);
      end
      col_cnt  = CNT_W'($countones(col_pat));
      match    = !no_open_ff && (col_pat == pat_ff);
      close_a  = !no_open_ff && !match;
      open_new = !match && (col_cnt > CNT_W'(1));

      nb_pat     = pat_ff;
      nb_cnt     = cnt_ff;
      nb_full    = full_ff;
      nb_no_open = no_open_ff;
      nb_run     = run_ff;
      nb_blocks  = blocks_ff;
      if (match) begin
         if (run_ff < RUN_MAX) nb_run = run_ff + LEN_W'(1);
      end else if (open_new) begin
         if (blocks_ff < BLK_SAT) nb_blocks = blocks_ff + BLKIDX_W'(1);
         nb_pat     = col_pat;
         nb_cnt     = col_cnt;
         nb_full    = (col_cnt == lanes);
         nb_no_open = 1'b0;
         nb_run     = LEN_W'(1);
      end else begin
         nb_no_open = 1'b1;
         nb_run     = '0;
         nb_pat     = '0;
      end

      new_mask_a  = close_a ? pat_ff : '0;
      new_mask_b  = (req_last_column && !nb_no_open) ? nb_pat : '0;
      any_records = (new_mask_a != '0) || (new_mask_b != '0);
   end

   // record selection
   always_comb begin
      phase_a  = (mask_a_ff != '0);
      sel_mask = phase_a ? mask_a_ff : mask_b_ff;
      sel_lane = lowest_lane(sel_mask);
      sel_bit  = MAX_SEQUENCES'(1) << sel_lane;
      final_record = phase_a ?
         (((mask_a_ff & ~sel_bit) == '0) && (mask_b_ff == '0)) :
         ((mask_b_ff & ~sel_bit) == '0);
   end

   assign status = '{has_records: any_records, last_record: final_record};

   // state update
   always_comb begin
      nseq_in    = csr_wr_en ? csr_wr_data : nseq_ff;
      for (int j = 0; j < MAX_SEQUENCES; j++) begin
         ctr_in[j]    = ctr_ff[j];
         starts_in[j] = starts_ff[j];
         snap_in[j]   = snap_ff[j];
      end
      pat_in     = pat_ff;
      cnt_in     = cnt_ff;
      full_in    = full_ff;
      no_open_in = no_open_ff;
      run_in     = run_ff;
      blocks_in  = blocks_ff;
      mask_a_in  = mask_a_ff;
      mask_b_in  = mask_b_ff;
      a_idx_in   = a_idx_ff;
      a_len_in   = a_len_ff;
      a_cnt_in   = a_cnt_ff;
      a_full_in  = a_full_ff;
      b_idx_in   = b_idx_ff;
      b_len_in   = b_len_ff;
      b_cnt_in   = b_cnt_ff;
      b_full_in  = b_full_ff;
      o_idx_in   = o_idx_ff;
      o_seq_in   = o_seq_ff;
      o_start_in = o_start_ff;
      o_len_in   = o_len_ff;
      o_cnt_in   = o_cnt_ff;
      o_full_in  = o_full_ff;
      o_last_in  = o_last_ff;

      if (cmd.accept) begin
         for (int j = 0; j < MAX_SEQUENCES; j++) begin
            ctr_in[j] = col_adv[j] ? ctr_ff[j] + CTR_W'(1) : ctr_ff[j];
            if (!match && open_new && col_pat[j]) starts_in[j] = ctr_in[j][START_W-1:0];
            if (close_a) snap_in[j] = starts_ff[j];
            if (req_last_column) ctr_in[j] = '1;
         end
         mask_a_in = new_mask_a;
         a_idx_in  = blocks_ff;
         a_len_in  = run_ff;
         a_cnt_in  = cnt_ff;
         a_full_in = full_ff;
         mask_b_in = new_mask_b;
         b_idx_in  = nb_blocks;
         b_len_in  = nb_run;
         b_cnt_in  = nb_cnt;
         b_full_in = nb_full;
         if (req_last_column) begin
            pat_in     = '0;
            cnt_in     = '0;
            full_in    = 1'b0;
            no_open_in = 1'b1;
            run_in     = '0;
            blocks_in  = '0;
         end else begin
            pat_in     = nb_pat;
            cnt_in     = nb_cnt;
            full_in    = nb_full;
            no_open_in = nb_no_open;
            run_in     = nb_run;
            blocks_in  = nb_blocks;
         end
      end

      if (cmd.pop) begin
         o_seq_in  = sel_lane;
         o_last_in = final_record;
         if (phase_a) begin
            o_idx_in   = a_idx_ff;
            o_start_in = snap_ff[sel_lane];
            o_len_in   = a_len_ff;
            o_cnt_in   = a_cnt_ff;
            o_full_in  = a_full_ff;
            mask_a_in  = mask_a_ff & ~sel_bit;
         end else begin
            o_idx_in   = b_idx_ff;
            o_start_in = starts_ff[sel_lane];
            o_len_in   = b_len_ff;
            o_cnt_in   = b_cnt_ff;
            o_full_in  = b_full_ff;
            mask_b_in  = mask_b_ff & ~sel_bit;
         end
      end
   end

   assign rsp_block_index    = o_idx_ff;
   assign rsp_sequence_index = o_seq_ff;
   assign rsp_start_position = o_start_ff;
   assign rsp_block_length   = o_len_ff;
   assign rsp_member_count   = o_cnt_ff;
   assign rsp_all_aligned    = o_full_ff;
   assign rsp_last_of_run    = o_last_ff;

endmodule

@@ rtl/core/alignment_block_extractor_top.sv @@
// ----------------------------------------------------------------------------
// Alignment block extractor
// A column that closes no block does not stall; one column per cycle.
// A column that closes blocks is accepted; its n member records are then
// registered out one per cycle while rsp_ready does not stall, req_ready low
// until the last one is popped; the record drain sets the rate.
// Synchronous reset sets counters to '1, clears block state; num_sequences is 2.
// ----------------------------------------------------------------------------
module alignment_block_extractor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [abe_pkg::NSEQ_W-1:0]     csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [abe_pkg::TAGS_W-1:0]     req_column_tags,
   input  logic                           req_last_column,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [abe_pkg::BLKIDX_W-1:0]   rsp_block_index,
   output logic [abe_pkg::LANE_W-1:0]     rsp_sequence_index,
   output logic [abe_pkg::START_W-1:0]    rsp_start_position,
   output logic [abe_pkg::LEN_W-1:0]      rsp_block_length,
   output logic [abe_pkg::CNT_W-1:0]      rsp_member_count,
   output logic                           rsp_all_aligned,
   output logic                           rsp_last_of_run
);
   import abe_pkg::*;

   cmd_type    cmd;
   status_type status;

   abe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   abe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_column_tags    (req_column_tags),
      .req_last_column    (req_last_column),
      .cmd                (cmd),
      .status             (status),
      .rsp_block_index    (rsp_block_index),
      .rsp_sequence_index (rsp_sequence_index),
      .rsp_start_position (rsp_start_position),
      .rsp_block_length   (rsp_block_length),
      .rsp_member_count   (rsp_member_count),
      .rsp_all_aligned    (rsp_all_aligned),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
